[rtl/core/sorted_list_insert_remove_top_macros.svh]
// Assertion macros shared by the sorted list checker.
// Depends on nothing; the including file supplies clock, reset and the expressions.
`ifndef SORTED_LIST_INSERT_REMOVE_TOP_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list check failed");

`endif

[rtl/core/slr_pkg.sv]
// Shared types and constants for the sorted list block.
// Used by the cell, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 2;
  localparam int IDX_W         = 4;
  localparam int STATUS_W      = 3;
  localparam int COUNT_W       = 5;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/slr_cell.sv]
// One position of the sorted list: holds an entry and compares it with the key.
// Depends on slr_pkg for the data width and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module slr_cell
  import slr_pkg::*;
(
  input  wire  logic                     clk,
  input  wire  cell_ctrl_t               ctrl,
  input  wire  logic signed [DATA_W-1:0] key,
  input  wire  logic                     valid,
  input  wire  logic signed [DATA_W-1:0] left_entry,
  input  wire  logic                     left_gt,
  input  wire  logic signed [DATA_W-1:0] right_entry,
  output logic signed [DATA_W-1:0]       entry,
  output logic                           gt,
  output logic                           match
);

  logic keep;

  always_comb begin
    gt    = !valid || (entry > key);
    keep  = valid && (entry < key);
    match = valid && (entry == key);
  end

  // An insert moves greater entries one place right; a delete closes the gap from the right.
  always_ff @(posedge clk) begin
    if (ctrl.ins && gt) begin
      entry <= left_gt ? left_entry : key;
    end else if (ctrl.del && !keep) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sorted_list_insert_remove_top.sv]
// Top level of the sorted list: a row of compare-and-shift cells plus the command sequencer.
// Depends on slr_pkg and slr_cell.
//
// Usage:
//   A command transaction is taken on a rising edge where start is high and busy is low;
//   cmd, value and index are sampled then. Every command gives exactly one result, shown
//   on status, count, read_value and removed_count for one cycle while done is high.
//   The receiver cannot stall, so results must be captured in that cycle.
// Command timing:
//   Insert, clear and read need no remove state: done rises in the cycle after the
//   transaction, and busy stays low, so one of these commands can be taken every cycle.
//   Insert places the value with every cell comparing and shifting in parallel.
//   Remove holds busy until no match is left: each cycle the cells drop one
//   matching entry by shifting their right neighbor in, and the cycle that finds no more
//   matches posts the result. A remove on an empty list answers without raising busy.
// Reset:
//   rst empties the list, clears done and busy; entry storage is not cleared since only
//   positions below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_remove_top
  import slr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire  logic                       clk,
  input  wire  logic                       rst,
  input  wire  logic                       start,
  output logic                             busy,
  input  wire  logic        [CMD_W-1:0]    cmd,
  input  wire  logic signed [DATA_W-1:0]   value,
  input  wire  logic        [IDX_W-1:0]    index,
  output logic                             done,
  output logic              [STATUS_W-1:0] status,
  output logic              [COUNT_W-1:0]  count,
  output logic signed       [DATA_W-1:0]   read_value,
  output logic              [COUNT_W-1:0]  removed_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int RD_N  = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);

  typedef enum logic {
    S_IDLE,
    S_REMOVE
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         rem;
  logic signed [DATA_W-1:0] key_q;

  logic signed [DATA_W-1:0] key;
  cell_ctrl_t               ctrl;
  logic                     full;
  logic                     found;
  logic signed [DATA_W-1:0] rd;

  logic signed [DATA_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]         gt;
  logic [DEPTH-1:0]         match;

  assign busy  = (state == S_REMOVE);
  assign key   = busy ? key_q : value;
  assign full  = (cnt == CNT_W'(DEPTH));
  assign found = |match;

  always_comb begin
    ctrl.ins = start && !busy && (cmd_t'(cmd) == CMD_INSERT) && !full;
    ctrl.del = busy && found;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     cell_valid;
    logic signed [DATA_W-1:0] left_entry;
    logic                     left_gt;
    logic signed [DATA_W-1:0] right_entry;

    assign cell_valid = (CNT_W'(i) < cnt);

    if (i == 0) begin : g_first
      assign left_entry = key;
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_entry = entry[i-1];
      assign left_gt    = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_body
      assign right_entry = entry[i+1];
    end

    slr_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key),
      .valid       (cell_valid),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (entry[i]),
      .gt          (gt[i]),
      .match       (match[i])
    );
  end

  always_comb begin
    rd = '0;
    for (int j = 0; j < RD_N; j++) begin
      if (index == IDX_W'(j)) begin
        rd = entry[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            read_value    <= '0;
            removed_count <= '0;
            status        <= ST_OK;
            unique case (cmd_t'(cmd))
              CMD_INSERT: begin
                done <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                  count  <= COUNT_W'(cnt);
                end else begin
                  cnt   <= cnt + 1'b1;
                  count <= COUNT_W'(cnt + 1'b1);
                end
              end
              CMD_REMOVE: begin
                if (cnt == '0) begin
                  done   <= 1'b1;
                  status <= ST_EMPTY;
                  count  <= '0;
                end else begin
                  state <= S_REMOVE;
                  key_q <= value;
                  rem   <= '0;
                end
              end
              CMD_CLEAR: begin
                done  <= 1'b1;
                cnt   <= '0;
                count <= '0;
              end
              CMD_READ: begin
                done  <= 1'b1;
                count <= COUNT_W'(cnt);
                if (CMP_W'(index) < CMP_W'(cnt)) begin
                  read_value <= rd;
                end else begin
                  status <= ST_RANGE;
                end
              end
              default: begin
                done <= 1'b0;
              end
            endcase
          end
        end
        S_REMOVE: begin
          if (found) begin
            cnt <= cnt - 1'b1;
            rem <= rem + 1'b1;
          end else begin
            state         <= S_IDLE;
            done          <= 1'b1;
            status        <= (rem == '0) ? ST_NOTFOUND : ST_OK;
            count         <= COUNT_W'(cnt);
            read_value    <= '0;
            removed_count <= COUNT_W'(rem);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/slr_checker.sv]
// Port-level checks for the sorted list top level, attached by a bind statement.
// Depends on slr_pkg and sorted_list_insert_remove_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_insert_remove_top_macros.svh"

module slr_checker
  import slr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic        [CMD_W-1:0]    cmd,
  input wire logic                       done,
  input wire logic        [STATUS_W-1:0] status,
  input wire logic        [COUNT_W-1:0]  count,
  input wire logic signed [DATA_W-1:0]   read_value,
  input wire logic        [COUNT_W-1:0]  removed_count
);

  `SLR_ASSERT_NEXT(a_short_cmd_done, clk, rst, start && !busy && cmd != CMD_REMOVE, done)
  `SLR_ASSERT_SAME(a_remove_end_done, clk, rst, !$past(rst) && $fell(busy), done)
  `SLR_ASSERT_SAME(a_full_count, clk, rst, done && status == ST_FULL, count == COUNT_W'(DEPTH))
  `SLR_ASSERT_SAME(a_range_zero, clk, rst, done && status == ST_RANGE, read_value == '0)
  `SLR_ASSERT_SAME(a_notfound_zero, clk, rst, done && status == ST_NOTFOUND, removed_count == '0)

endmodule

bind sorted_list_insert_remove_top slr_checker #(.DEPTH(DEPTH)) u_slr_checker (.*);

`default_nettype wire

[tb/sorted_list_insert_remove_top_tb.sv]
// Self-checking testbench for the sorted list: directed command table, then random traffic.
// Results are compared with the table's values or an in-bench model; depends on slr_pkg and the RTL.
`timescale 1ns / 1ps

module sorted_list_insert_remove_top_tb;
  import slr_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_FIRST  = 700;
  localparam int QUIET_LAST   = 1100;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       removed_count;
  } list_result_t;

  typedef struct {
    cmd_t                     op;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    int                       reps;
    bit                       typed;
    logic [STATUS_W-1:0]      w_status;
    logic [COUNT_W-1:0]       w_count;
    logic signed [DATA_W-1:0] w_read;
    logic [COUNT_W-1:0]       w_removed;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic [CMD_W-1:0]           cmd = CMD_CLEAR;
  logic signed [DATA_W-1:0]   value = '0;
  logic [IDX_W-1:0]           index = '0;
  logic                       busy;
  logic                       done;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_W-1:0]         count;
  logic signed [DATA_W-1:0]   read_value;
  logic [COUNT_W-1:0]         removed_count;

  logic signed [DATA_W-1:0]   list_mem [LIST_DEPTH];
  int                         list_len = 0;
  list_result_t               pending_results [$];
  int                         error_count = 0;

  stim_row_t directed_rows [17] = '{
    '{CMD_READ,   32'sd0,          4'd0,  1,  1'b1, ST_RANGE,    5'd0,  32'sd0,          5'd0},
    '{CMD_REMOVE, 32'sd5,          4'd0,  1,  1'b1, ST_EMPTY,    5'd0,  32'sd0,          5'd0},
    '{CMD_CLEAR,  32'sd0,          4'd0,  1,  1'b1, ST_OK,       5'd0,  32'sd0,          5'd0},
    '{CMD_INSERT, 32'sh7FFF_FFFF,  4'd0,  1,  1'b1, ST_OK,       5'd1,  32'sd0,          5'd0},
    '{CMD_INSERT, 32'sh8000_0000,  4'd0,  1,  1'b1, ST_OK,       5'd2,  32'sd0,          5'd0},
    '{CMD_INSERT, 32'sd0,          4'd0,  1,  1'b0, ST_OK,       5'd0,  32'sd0,          5'd0},
    '{CMD_INSERT, 32'sd0,          4'd0,  1,  1'b0, ST_OK,       5'd0,  32'sd0,          5'd0},
    '{CMD_READ,   32'sd0,          4'd0,  1,  1'b1, ST_OK,       5'd4,  32'sh8000_0000,  5'd0},
    '{CMD_READ,   32'sd0,          4'd3,  1,  1'b1, ST_OK,       5'd4,  32'sh7FFF_FFFF,  5'd0},
    '{CMD_READ,   32'sd0,          4'd15, 1,  1'b1, ST_RANGE,    5'd4,  32'sd0,          5'd0},
    '{CMD_REMOVE, 32'sd12345,      4'd0,  1,  1'b1, ST_NOTFOUND, 5'd4,  32'sd0,          5'd0},
    '{CMD_REMOVE, 32'sd0,          4'd0,  1,  1'b1, ST_OK,       5'd2,  32'sd0,          5'd2},
    '{CMD_INSERT, 32'shFFFF_FFFF,  4'd5,  14, 1'b0, ST_OK,       5'd0,  32'sd0,          5'd0},
    '{CMD_INSERT, 32'sd1,          4'd0,  1,  1'b1, ST_FULL,     5'd16, 32'sd0,          5'd0},
    '{CMD_READ,   32'sd0,          4'd15, 1,  1'b0, ST_OK,       5'd0,  32'sd0,          5'd0},
    '{CMD_REMOVE, 32'shFFFF_FFFF,  4'd0,  1,  1'b1, ST_OK,       5'd2,  32'sd0,          5'd14},
    '{CMD_CLEAR,  32'sd0,          4'd0,  1,  1'b1, ST_OK,       5'd0,  32'sd0,          5'd0}
  };

  sorted_list_insert_remove_top DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .value         (value),
    .index         (index),
    .done          (done),
    .status        (status),
    .count         (count),
    .read_value    (read_value),
    .removed_count (removed_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one command to the in-bench list and returns the result it should give.
  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] op,
                                                      logic signed [DATA_W-1:0] val,
                                                      logic [IDX_W-1:0] idx);
    list_result_t r;
    int pos;
    int keep;
    int removed;
    r = '0;
    r.status = ST_OK;
    removed = 0;
    case (op)
      CMD_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = list_len;
          while (pos > 0 && list_mem[pos-1] > val) begin
            list_mem[pos] = list_mem[pos-1];
            pos--;
          end
          list_mem[pos] = val;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          keep = 0;
          for (int i = 0; i < list_len; i++) begin
            if (list_mem[i] == val) begin
              removed++;
            end else begin
              list_mem[keep] = list_mem[i];
              keep++;
            end
          end
          if (removed == 0) begin
            r.status = ST_NOTFOUND;
          end
          list_len = keep;
        end
      end
      CMD_CLEAR: begin
        list_len = 0;
      end
      default: begin
        if (int'(idx) < list_len) begin
          r.read_value = list_mem[idx];
        end else begin
          r.status = ST_RANGE;
        end
      end
    endcase
    r.count = COUNT_W'(list_len);
    r.removed_count = COUNT_W'(removed);
    return r;
  endfunction

  // Holds one command transaction until it is taken, then records its expected result.
  task automatic send_command(input logic [CMD_W-1:0] op, input logic signed [DATA_W-1:0] val,
                              input logic [IDX_W-1:0] idx, input bit typed,
                              input list_result_t typed_result);
    list_result_t predicted;
    start <= 1'b1;
    cmd   <= op;
    value <= val;
    index <= idx;
    do @(posedge clk); while (busy);
    predicted = apply_list_command(op, val, idx);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        error_count = error_count + 1;
        $display("%0t: unexpected result: status %0d count %0d read %0d removed %0d",
                 $time, status, count, read_value, removed_count);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          error_count = error_count + 1;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
        if (count !== want.count) begin
          error_count = error_count + 1;
          $display("%0t: count expected %0d actual %0d", $time, want.count, count);
        end
        if (read_value !== want.read_value) begin
          error_count = error_count + 1;
          $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                   read_value);
        end
        if (removed_count !== want.removed_count) begin
          error_count = error_count + 1;
          $display("%0t: removed_count expected %0d actual %0d", $time, want.removed_count,
                   removed_count);
        end
      end
    end
  end

  initial begin
    list_result_t typed_result;
    logic [CMD_W-1:0] op;
    logic signed [DATA_W-1:0] val;
    int pick;
    int insert_weight;
    int wait_cycles;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      typed_result = '{directed_rows[r].w_status, directed_rows[r].w_count,
                       directed_rows[r].w_read, directed_rows[r].w_removed};
      repeat (directed_rows[r].reps) begin
        send_command(directed_rows[r].op, directed_rows[r].value, directed_rows[r].index,
                     directed_rows[r].typed, typed_result);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 500 == 0) begin
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      insert_weight = ((n / 150) % 2 == 1) ? 70 : 42;
      pick = $urandom_range(0, 99);
      if (pick < insert_weight) begin
        op = CMD_INSERT;
      end else if (pick < insert_weight + (100 - insert_weight) / 3) begin
        op = CMD_REMOVE;
      end else if (pick < 95) begin
        op = CMD_READ;
      end else begin
        op = CMD_CLEAR;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4 && list_len > 0) begin
        val = list_mem[$urandom_range(0, list_len - 1)];
      end else if (pick < 7) begin
        val = $signed(DATA_W'($urandom_range(0, 8))) - 32'sd4;
      end else begin
        val = $urandom;
      end
      send_command(op, val, IDX_W'($urandom_range(0, 15)), 1'b0, '0);
      if ((n < QUIET_FIRST || n > QUIET_LAST) && $urandom_range(0, 99) < 26) begin
        pause_sender($urandom_range(1, 3));
      end
    end

    start <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count = error_count + pending_results.size();
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/slr_pkg.sv
rtl/core/slr_cell.sv
rtl/core/sorted_list_insert_remove_top.sv
rtl/core/slr_checker.sv
tb/sorted_list_insert_remove_top_tb.sv
